// ===== rtl/cwfs_pkg.sv =====
// shared constants, types and register codes of the current window fault supervisor
package cwfs_pkg;

    // block size of the running average, must be a power of two
    localparam int AVG_SAMPLES = 16;
    localparam int ADC_LEVELS  = 1024;

    localparam int ADC_W    = 10;
    localparam int LEVEL_W  = 11;
    localparam int OFFSET_W = 10;
    localparam int COUNT_W  = 8;
    localparam int TOTAL_W  = 16;
    localparam int CFG_W    = 11;
    localparam int INDEX_W  = 2;

    localparam int LEVEL_MAX = 1023;
    localparam int LEVEL_MIN = -1024;
    localparam int COUNT_MAX = 255;
    localparam int TOTAL_MAX = 65535;

    localparam int AVG_SHIFT = $clog2(AVG_SAMPLES);
    localparam int CNT_W     = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
    localparam int SUM_W     = $clog2(AVG_SAMPLES * (ADC_LEVELS - 1) + 1);
    localparam int QUOT_W    = SUM_W - AVG_SHIFT;
    localparam int DIFF_W    = ((QUOT_W > OFFSET_W) ? QUOT_W : OFFSET_W) + 1;

    typedef enum logic [INDEX_W-1:0] {
        REG_WINDOW_LOW  = 2'd0,
        REG_WINDOW_HIGH = 2'd1,
        REG_ZERO_OFFSET = 2'd2,
        REG_FAULT_LIMIT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_TOGGLE = 1'b1
    } mode_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] window_low;
        logic signed [LEVEL_W-1:0] window_high;
        logic [OFFSET_W-1:0]       zero_offset;
        logic [COUNT_W-1:0]        fault_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      miss;
    } avg_t;

    typedef struct packed {
        logic                      running;
        logic                      fault;
        logic                      channel;
        logic                      avg_valid;
        logic signed [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0]        miss_count;
        logic [COUNT_W-1:0]        run_errors;
        logic [TOTAL_W-1:0]        total_errors;
    } result_t;

endpackage

// ===== rtl/cwfs_avg.sv =====
// block average: divide, remove offset, saturate and check against the window
module cwfs_avg (
    input  logic [cwfs_pkg::SUM_W-1:0] sum_i,
    input  cwfs_pkg::cfg_t             cfg_i,
    output cwfs_pkg::avg_t             avg_o
);
    import cwfs_pkg::*;

    logic [QUOT_W-1:0]        quot;
    logic signed [DIFF_W-1:0] diff;
    logic signed [LEVEL_W-1:0] level;

    always_comb begin
        quot = sum_i[SUM_W-1:AVG_SHIFT];
        diff = $signed(DIFF_W'(quot)) - $signed(DIFF_W'(cfg_i.zero_offset));
        if (diff > LEVEL_MAX) begin
            level = LEVEL_W'(LEVEL_MAX);
        end else if (diff < LEVEL_MIN) begin
            level = LEVEL_W'(LEVEL_MIN);
        end else begin
            level = LEVEL_W'(diff);
        end
        avg_o.level = level;
        // an inverted window makes every average a miss
        avg_o.miss  = (level < cfg_i.window_low) || (level > cfg_i.window_high);
    end

endmodule

// ===== rtl/cwfs_ctrl.sv =====
// supervisor state, config registers and per-word state update
module cwfs_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cwfs_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [cwfs_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                accept_i,
    input  logic                                mode_i,
    input  logic [cwfs_pkg::ADC_W-1:0]          code_i,
    output cwfs_pkg::result_t                   result_o
);
    import cwfs_pkg::*;

    cfg_t cfg_reg;

    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [LEVEL_W-1:0] level_reg, level_next;
    logic [COUNT_W-1:0]        miss_reg, miss_next;
    logic                      running_reg, running_next;
    logic                      fault_reg, fault_next;
    logic                      channel_reg, channel_next;
    logic [COUNT_W-1:0]        run_err_reg, run_err_next;
    logic [TOTAL_W-1:0]        total_err_reg, total_err_next;

    logic [ADC_W-1:0] code_sat;
    logic [SUM_W-1:0] sum_acc;
    logic             avg_valid;
    avg_t             avg;

    cwfs_avg u_avg (
        .sum_i (sum_acc),
        .cfg_i (cfg_reg),
        .avg_o (avg)
    );

    always_comb begin
        if ({1'b0, code_i} > (ADC_W + 1)'(ADC_LEVELS - 1)) begin
            code_sat = ADC_W'(ADC_LEVELS - 1);
        end else begin
            code_sat = code_i;
        end
        sum_acc = sum_reg + SUM_W'(code_sat);

        sum_next       = sum_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        miss_next      = miss_reg;
        running_next   = running_reg;
        fault_next     = fault_reg;
        channel_next   = channel_reg;
        run_err_next   = run_err_reg;
        total_err_next = total_err_reg;
        avg_valid      = 1'b0;

        if (accept_i) begin
            if (mode_t'(mode_i) == MODE_TOGGLE) begin
                running_next = !running_reg;
                if (!running_reg) begin
                    // restart after a fault moves to the other channel
                    if (fault_reg) begin
                        channel_next = !channel_reg;
                        fault_next   = 1'b0;
                    end
                end else if (!fault_reg) begin
                    run_err_next = '0;
                end
                miss_next = '0;
            end else if (running_reg && !fault_reg) begin
                if (miss_reg >= cfg_reg.fault_limit) begin
                    fault_next = 1'b1;
                    if (run_err_reg != COUNT_W'(COUNT_MAX)) begin
                        run_err_next = run_err_reg + 1'b1;
                    end
                    if (total_err_reg != TOTAL_W'(TOTAL_MAX)) begin
                        total_err_next = total_err_reg + 1'b1;
                    end
                end else if (count_reg == CNT_W'(AVG_SAMPLES - 1)) begin
                    sum_next   = '0;
                    count_next = '0;
                    level_next = avg.level;
                    avg_valid  = 1'b1;
                    if (avg.miss) begin
                        if (miss_reg != COUNT_W'(COUNT_MAX)) begin
                            miss_next = miss_reg + 1'b1;
                        end
                    end else begin
                        miss_next = '0;
                    end
                end else begin
                    sum_next   = sum_acc;
                    count_next = count_reg + 1'b1;
                end
            end
        end

        result_o.running      = running_next;
        result_o.fault        = fault_next;
        result_o.channel      = channel_next;
        result_o.avg_valid    = avg_valid;
        result_o.level        = level_next;
        result_o.miss_count   = miss_next;
        result_o.run_errors   = run_err_next;
        result_o.total_errors = total_err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_low  <= LEVEL_W'(LEVEL_MIN);
            cfg_reg.window_high <= LEVEL_W'(LEVEL_MAX);
            cfg_reg.zero_offset <= OFFSET_W'(512);
            cfg_reg.fault_limit <= COUNT_W'(3);
            sum_reg       <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            miss_reg      <= '0;
            running_reg   <= 1'b0;
            fault_reg     <= 1'b0;
            channel_reg   <= 1'b0;
            run_err_reg   <= '0;
            total_err_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_index))
                    REG_WINDOW_LOW:  cfg_reg.window_low  <= cfg_wdata;
                    REG_WINDOW_HIGH: cfg_reg.window_high <= cfg_wdata;
                    REG_ZERO_OFFSET: cfg_reg.zero_offset <= cfg_wdata[OFFSET_W-1:0];
                    REG_FAULT_LIMIT: cfg_reg.fault_limit <= cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            miss_reg      <= miss_next;
            running_reg   <= running_next;
            fault_reg     <= fault_next;
            channel_reg   <= channel_next;
            run_err_reg   <= run_err_next;
            total_err_reg <= total_err_next;
        end
    end

endmodule

// ===== rtl/current_window_fault_supervisor_unit.sv =====
// top level of the two-channel current window fault supervisor
//
// One input word is taken per clock and answered by exactly one result word,
// which is held in the result register. A sample word (tuser 0) counts
// only while the active channel runs without a fault: samples are summed
// over blocks of 16, the block average minus zero_offset (saturated to
// -1024..1023) is checked against window_low..window_high, and
// consecutive misses are counted. Once the miss count has reached
// fault_limit, the next sample latches the fault instead of being summed and
// bumps the saturating run and total error counters. A toggle word (tuser 1)
// flips the running state and clears the miss count; restarting after a
// fault moves to the other channel and clears the fault, and a clean stop
// clears the run error count. Throughput is one word per cycle: the state
// update is a single add, shift, subtract and compare path between the state
// registers, and a new word enters in the same cycle that the previous result
// is taken, so input stalls only while a result waits on m_tready.
// Config writes are meant for idle periods only.
module current_window_fault_supervisor_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,

    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // adc_sample[9:0], zero fill
    input  logic        s_tuser,   // mode

    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // running, fault, active_channel,
                                   // average_level[10:0], out_of_window_count[7:0],
                                   // run_error_count[7:0], total_error_count[15:0],
                                   // zero fill
    output logic        m_tuser    // average_valid
);
    import cwfs_pkg::*;

    logic    accept;
    result_t result;
    result_t result_reg;
    logic    m_valid_reg, m_valid_next;

    // a new word enters when the result slot is empty or drains this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    cwfs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept_i  (accept),
        .mode_i    (s_tuser),
        .code_i    (s_tdata[ADC_W-1:0]),
        .result_o  (result)
    );

    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // result slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload carries no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result_reg.avg_valid;
    assign m_tdata  = {2'b00,
                       result_reg.total_errors,
                       result_reg.run_errors,
                       result_reg.miss_count,
                       result_reg.level,
                       result_reg.channel,
                       result_reg.fault,
                       result_reg.running};

endmodule

// ===== tb/current_window_fault_supervisor_unit_tb.sv =====
// self-checking testbench of the current window fault supervisor, with a cycle-free status predictor
module current_window_fault_supervisor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwfs_pkg::*;

    localparam int CODE_MAX    = ADC_LEVELS - 1;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off to fill the block
    localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either side
    localparam int PRINT_LIMIT = 200;
    localparam int SEG_ITEMS   = 110;   // random words per config segment
    localparam int MISS_BLOCKS = 5;     // missed blocks sent under the largest limit

    // clock, reset and block inputs, all known from time zero
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [47:0]         m_tdata;
    logic                m_tuser;

    // traffic shaping, written by the stimulus, read by the driver and the sink
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int fail_count     = 0;
    int drift          = 0;

    // predicted status words, oldest first
    result_t pending_status[$];

    // predictor copy of the registers
    logic signed [LEVEL_W-1:0] win_low;
    logic signed [LEVEL_W-1:0] win_high;
    logic [OFFSET_W-1:0]       zero_code;
    logic [COUNT_W-1:0]        miss_limit;

    // predictor copy of the supervisor state
    logic [SUM_W-1:0]          block_sum;
    logic [CNT_W:0]            block_fill;
    logic signed [LEVEL_W-1:0] held_level;
    logic [COUNT_W-1:0]        miss_run;
    logic                      is_on;
    logic                      is_faulted;
    logic                      chan_sel;
    logic [COUNT_W-1:0]        run_faults;
    logic [TOTAL_W-1:0]        all_faults;

    current_window_fault_supervisor_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // adc_sample[9:0], zero fill
        .s_tuser   (s_tuser),    // mode
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // running, fault, active_channel, average_level[10:0],
                                 // out_of_window_count[7:0], run_error_count[7:0],
                                 // total_error_count[15:0], zero fill
        .m_tuser   (m_tuser)     // average_valid
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic reset_predictor();
        win_low    = LEVEL_W'(LEVEL_MIN);
        win_high   = LEVEL_W'(LEVEL_MAX);
        zero_code  = OFFSET_W'(512);
        miss_limit = COUNT_W'(3);
        block_sum  = '0;
        block_fill = '0;
        held_level = '0;
        miss_run   = '0;
        is_on      = 1'b0;
        is_faulted = 1'b0;
        chan_sel   = 1'b0;
        run_faults = '0;
        all_faults = '0;
    endtask

    // status word after one accepted input word
    function automatic result_t advance_supervisor(mode_t mode, logic [ADC_W-1:0] code);
        result_t r;
        int      mean;
        r.avg_valid = 1'b0;
        if (mode == MODE_TOGGLE) begin
            is_on = ~is_on;
            if (is_on) begin
                // restart after a fault moves to the other channel
                if (is_faulted) begin
                    chan_sel   = ~chan_sel;
                    is_faulted = 1'b0;
                end
            end else if (!is_faulted) begin
                run_faults = '0;
            end
            miss_run = '0;
        end else if (is_on && !is_faulted) begin
            if (miss_run >= miss_limit) begin
                // armed: this sample latches the fault instead of being summed
                is_faulted = 1'b1;
                if (run_faults != COUNT_W'(COUNT_MAX)) run_faults = run_faults + 1'b1;
                if (all_faults != TOTAL_W'(TOTAL_MAX)) all_faults = all_faults + 1'b1;
            end else begin
                block_sum  = block_sum + code;
                block_fill = block_fill + 1'b1;
                if (block_fill >= AVG_SAMPLES) begin
                    mean = int'(block_sum) / AVG_SAMPLES - int'(zero_code);
                    if (mean > LEVEL_MAX) mean = LEVEL_MAX;
                    if (mean < LEVEL_MIN) mean = LEVEL_MIN;
                    held_level  = LEVEL_W'(mean);
                    block_sum   = '0;
                    block_fill  = '0;
                    r.avg_valid = 1'b1;
                    if (mean < win_low || mean > win_high) begin
                        if (miss_run != COUNT_W'(COUNT_MAX)) miss_run = miss_run + 1'b1;
                    end else begin
                        miss_run = '0;
                    end
                end
            end
        end
        r.running      = is_on;
        r.fault        = is_faulted;
        r.channel      = chan_sel;
        r.level        = held_level;
        r.miss_count   = miss_run;
        r.run_errors   = run_faults;
        r.total_errors = all_faults;
        return r;
    endfunction

    function automatic result_t unpack_status(logic [47:0] d, logic u);
        result_t r;
        r.running      = d[0];
        r.fault        = d[1];
        r.channel      = d[2];
        r.level        = d[13:3];
        r.miss_count   = d[21:14];
        r.run_errors   = d[29:22];
        r.total_errors = d[45:30];
        r.avg_valid    = u;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic check_field(string what, int got, int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // result sink: one status word per accepted input word, in order
    always @(posedge aclk) begin : status_checker
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_status(m_tdata, m_tuser);
            if (pending_status.size() == 0) begin
                report_mismatch("status word with none pending", 0, 0);
            end else begin
                want = pending_status.pop_front();
                check_field("running", got.running, want.running);
                check_field("fault", got.fault, want.fault);
                check_field("active_channel", got.channel, want.channel);
                check_field("average_valid", got.avg_valid, want.avg_valid);
                check_field("average_level", int'(got.level), int'(want.level));
                check_field("out_of_window_count", got.miss_count, want.miss_count);
                check_field("run_error_count", got.run_errors, want.run_errors);
                check_field("total_error_count", got.total_errors, want.total_errors);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on traffic that stops moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // offer one word, predict its status once it is taken; entered just after an edge
    task automatic send_word(mode_t mode, logic [ADC_W-1:0] code);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, code};
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_status.push_back(advance_supervisor(mode, code));
    endtask

    // sender pause until every pending status word is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // only while the block is idle
    task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_WINDOW_LOW:  win_low    = value;
            REG_WINDOW_HIGH: win_high   = value;
            REG_ZERO_OFFSET: zero_code  = value[OFFSET_W-1:0];
            REG_FAULT_LIMIT: miss_limit = value[COUNT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // leave the block running on a clean channel
    task automatic bring_up();
        if (is_on) send_word(MODE_TOGGLE, ADC_W'($urandom_range(CODE_MAX)));
        send_word(MODE_TOGGLE, ADC_W'($urandom_range(CODE_MAX)));
    endtask

    task automatic test_directed_cases();
        drain_results();
        write_reg(REG_WINDOW_LOW, CFG_W'(LEVEL_MIN));
        write_reg(REG_WINDOW_HIGH, CFG_W'(LEVEL_MAX));
        write_reg(REG_ZERO_OFFSET, CFG_W'(512));
        write_reg(REG_FAULT_LIMIT, CFG_W'(0));
        send_word(MODE_SAMPLE, ADC_W'(CODE_MAX));   // stopped: ignored
        send_word(MODE_TOGGLE, ADC_W'(0));          // start
        send_word(MODE_SAMPLE, ADC_W'(0));          // zero limit: faults at once
        send_word(MODE_SAMPLE, ADC_W'(CODE_MAX));   // faulted: ignored
        send_word(MODE_TOGGLE, ADC_W'(CODE_MAX));   // stop with fault keeps run errors
        send_word(MODE_TOGGLE, ADC_W'(0));          // restart swaps channel
        send_word(MODE_TOGGLE, ADC_W'(0));          // clean stop clears run errors
        drain_results();
        // inverted window: every average misses
        write_reg(REG_FAULT_LIMIT, CFG_W'(1));
        write_reg(REG_WINDOW_LOW, CFG_W'(LEVEL_MAX));
        write_reg(REG_WINDOW_HIGH, CFG_W'(LEVEL_MIN));
        send_word(MODE_TOGGLE, ADC_W'(0));
        for (int k = 0; k < AVG_SAMPLES; k++) begin
            // toggling mid-block keeps the partial sum
            if (k == AVG_SAMPLES / 2) begin
                send_word(MODE_TOGGLE, ADC_W'(0));
                send_word(MODE_TOGGLE, ADC_W'(0));
            end
            send_word(MODE_SAMPLE, (k % 2) ? ADC_W'(CODE_MAX) : ADC_W'(0));
        end
        send_word(MODE_SAMPLE, ADC_W'(CODE_MAX));   // armed: latches the fault
    endtask

    task automatic shuffle_config(int phase, int seg);
        int lo;
        int hi;
        int tmp;
        int ofs;
        int lim;
        drain_results();
        lo = $urandom_range(400) - 200;
        hi = lo + $urandom_range(300);
        if ($urandom_range(6) == 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        ofs = (phase == 2) ? ((seg == 0) ? 0 : CODE_MAX) : $urandom_range(CODE_MAX);
        lim = (phase == 3 && seg == 1) ? COUNT_MAX : $urandom_range(4, 1);
        write_reg(REG_WINDOW_LOW, CFG_W'(lo));
        write_reg(REG_WINDOW_HIGH, CFG_W'(hi));
        // unused upper bits of the narrow registers carry random junk
        write_reg(REG_ZERO_OFFSET, {1'($urandom_range(1)), OFFSET_W'(ofs)});
        write_reg(REG_FAULT_LIMIT, {3'($urandom_range(7)), COUNT_W'(lim)});
    endtask

    // mostly samples near a drifting level around the window, toggles when not live
    task automatic send_random_item();
        int code;
        int toggle_pct;
        toggle_pct = (is_on && !is_faulted) ? 3 : 40;
        if ($urandom_range(99) < toggle_pct) begin
            send_word(MODE_TOGGLE, ADC_W'($urandom_range(CODE_MAX)));
        end else begin
            if ($urandom_range(15) == 0) drift = $urandom_range(600) - 300;
            if ($urandom_range(99) < 80) begin
                code = int'(zero_code) + drift + $urandom_range(128) - 64;
                if (code < 0) code = 0;
                if (code > CODE_MAX) code = CODE_MAX;
            end else begin
                code = $urandom_range(CODE_MAX);
            end
            send_word(MODE_SAMPLE, ADC_W'(code));
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                shuffle_config(phase, seg);
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    // back-pressure: sink holds off while the sender keeps offering
                    if (phase == 0 && seg == 0 && n == 40) hold_asked++;
                    // sender pauses until the block is empty
                    if (phase == 2 && seg == 0 && n == 55) drain_results();
                    send_random_item();
                end
            end
        end
    endtask

    // largest fault limit: several missed blocks in a row without a fault
    task automatic test_miss_limit_extreme();
        send_idle_pct  = 0;
        recv_stall_pct = 34;
        drain_results();
        write_reg(REG_WINDOW_LOW, CFG_W'(LEVEL_MAX));
        write_reg(REG_WINDOW_HIGH, CFG_W'(LEVEL_MIN));
        write_reg(REG_FAULT_LIMIT, CFG_W'(COUNT_MAX));
        bring_up();
        for (int n = 0; n < MISS_BLOCKS * AVG_SAMPLES; n++)
            send_word(MODE_SAMPLE, ADC_W'($urandom_range(CODE_MAX)));
    endtask

    // drive the run error counter into saturation with a zero limit
    task automatic test_error_saturation();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        write_reg(REG_FAULT_LIMIT, CFG_W'(0));
        bring_up();
        for (int n = 0; n < COUNT_MAX + 3; n++) begin
            send_word(MODE_SAMPLE, ADC_W'($urandom_range(CODE_MAX)));
            send_word(MODE_TOGGLE, ADC_W'($urandom_range(CODE_MAX)));
            send_word(MODE_TOGGLE, ADC_W'($urandom_range(CODE_MAX)));
        end
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_random_traffic();
        test_miss_limit_extreme();
        test_error_saturation();

        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== current_window_fault_supervisor_unit.f =====
rtl/cwfs_pkg.sv
rtl/cwfs_avg.sv
rtl/cwfs_ctrl.sv
rtl/current_window_fault_supervisor_unit.sv
tb/current_window_fault_supervisor_unit_tb.sv
